/* src/fccw_pkg.sv */
// ----------------------------------------------------------------------------
// fccw_pkg
// shared types and constants of the allocation table chain walker
// ----------------------------------------------------------------------------
package fccw_pkg;

  localparam int DEF_TABLE_DEPTH = 8192;
  localparam int DEF_MAX_CHAIN   = 64;
  localparam int CMD_QUEUE_DEPTH = 2;

  localparam int CNT_W   = 14;
  localparam int LIMIT_W = 7;
  localparam int IDX_W   = 13;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_WALK  = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  localparam logic RES_CHAIN = 1'b0;
  localparam logic RES_COUNT = 1'b1;

  localparam logic [31:0] INVALID_PTR = 32'hFFFF_FFFF;
  localparam logic [7:0]  END_FLAG    = 8'hFF;
  localparam logic [31:0] FREE_WORD   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   entry_index;
    logic [31:0]        entry_value;
    logic [31:0]        start_cluster;
    logic [LIMIT_W-1:0] chain_limit;
  } in_item_t;

  typedef struct packed {
    logic             result_type;
    logic [31:0]      cluster;
    logic             last;
    logic             empty_chain;
    logic [CNT_W-1:0] free_total;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   entry_index;
    logic [31:0]        entry_value;
    logic [31:0]        start_cluster;
    logic [LIMIT_W-1:0] cap;
    logic               empty_walk;
  } cmd_t;

endpackage

/* src/fccw_front.sv */
// ----------------------------------------------------------------------------
// fccw_front
// takes items, works out the walk cap, queues commands for the back end
// ----------------------------------------------------------------------------
module fccw_front #(
  parameter int MAX_CHAIN = fccw_pkg::DEF_MAX_CHAIN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  fccw_pkg::in_item_t         in_data,
  input  logic [fccw_pkg::CNT_W-1:0] eff_count,
  output logic                       cmd_valid,
  input  logic                       cmd_pop,
  output fccw_pkg::cmd_t             cmd_head
);
  import fccw_pkg::*;

  localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int QW = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t              queue_r [CMD_QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QW-1:0]     fill_r, fill_nxt;
  logic              accept;
  logic              enq;
  logic              deq;
  logic [LIMIT_W-1:0] cap;
  cmd_t              cmd_new;

  // cap: limit, or table count when limit is zero, saturated
  always_comb begin
    if (in_data.chain_limit == '0) begin
      if ({{(32-CNT_W){1'b0}}, eff_count} > 32'(MAX_CHAIN)) begin
        cap = LIMIT_W'(MAX_CHAIN);
      end else begin
        cap = LIMIT_W'(eff_count);
      end
    end else if ({{(32-LIMIT_W){1'b0}}, in_data.chain_limit} > 32'(MAX_CHAIN)) begin
      cap = LIMIT_W'(MAX_CHAIN);
    end else begin
      cap = in_data.chain_limit;
    end
  end

  always_comb begin
    cmd_new.kind          = in_data.kind;
    cmd_new.entry_index   = in_data.entry_index;
    cmd_new.entry_value   = in_data.entry_value;
    cmd_new.start_cluster = in_data.start_cluster;
    cmd_new.cap           = cap;
    cmd_new.empty_walk    = (in_data.start_cluster == INVALID_PTR) || (cap == '0);
  end

  assign in_full   = (fill_r == QW'(CMD_QUEUE_DEPTH));
  assign accept    = in_push && !in_full;
  // unknown kind is taken and dropped here
  assign enq       = accept && (in_data.kind == KIND_WRITE || in_data.kind == KIND_WALK ||
                                in_data.kind == KIND_COUNT);
  assign cmd_valid = (fill_r != '0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd_head  = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (enq && !deq) begin
      fill_nxt = fill_r + QW'(1);
    end else if (deq && !enq) begin
      fill_nxt = fill_r - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      queue_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

/* src/fccw_back.sv */
// ----------------------------------------------------------------------------
// fccw_back
// owns the allocation table; runs writes, chain walks and free scans
// ----------------------------------------------------------------------------
module fccw_back #(
  parameter int TABLE_DEPTH = fccw_pkg::DEF_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  input  fccw_pkg::cmd_t             cmd_head,
  input  logic [fccw_pkg::CNT_W-1:0] eff_count,
  output logic                       out_empty,
  input  logic                       out_pop,
  output fccw_pkg::out_item_t        out_data
);
  import fccw_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_STEP    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_CNT_OUT = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  logic [31:0]        mem [TABLE_DEPTH];
  logic [31:0]        rd_r;

  logic [2:0]         state_r, state_nxt;
  logic [31:0]        cur_r, cur_nxt;
  logic [LIMIT_W-1:0] n_r, n_nxt;
  logic [LIMIT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   free_r, free_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic               mem_we;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               emit;
  out_item_t          emit_data;
  logic               slot_free;
  logic               pop_ok;
  logic               cur_ge_count;
  logic               idx_in_range;
  logic               scan_more;
  logic               walk_last;

  assign pop_ok       = out_pop && out_valid_r;
  assign slot_free    = !out_valid_r || out_pop;
  assign cur_ge_count = cur_r >= {{(32-CNT_W){1'b0}}, eff_count};
  assign idx_in_range = {{(32-IDX_W){1'b0}}, cmd_head.entry_index} < 32'(TABLE_DEPTH);
  assign scan_more    = i_r < eff_count;
  assign walk_last    = (rd_r[31:24] == END_FLAG) || ((n_r + LIMIT_W'(1)) == cap_r);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    n_nxt     = n_r;
    cap_nxt   = cap_r;
    i_nxt     = i_r;
    free_nxt  = free_r;
    pend_nxt  = pend_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    emit      = 1'b0;
    emit_data = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd_head.kind)
            KIND_WRITE: begin
              mem_we = idx_in_range;
            end
            KIND_WALK: begin
              if (cmd_head.empty_walk) begin
                state_nxt = ST_EMPTY;
              end else begin
                cur_nxt   = cmd_head.start_cluster;
                n_nxt     = '0;
                cap_nxt   = cmd_head.cap;
                state_nxt = ST_STEP;
              end
            end
            KIND_COUNT: begin
              i_nxt     = '0;
              free_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_STEP: begin
        if (cur_ge_count) begin
          // beyond the table: emit and stop without a read
          if (slot_free) begin
            emit                  = 1'b1;
            emit_data.result_type = RES_CHAIN;
            emit_data.cluster     = cur_r;
            emit_data.last        = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(cur_r);
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          emit                  = 1'b1;
          emit_data.result_type = RES_CHAIN;
          emit_data.cluster     = cur_r;
          emit_data.last        = walk_last;
          if (walk_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt   = {8'd0, rd_r[23:0]};
            n_nxt     = n_r + LIMIT_W'(1);
            state_nxt = ST_STEP;
          end
        end
      end
      ST_SCAN: begin
        pend_nxt = 1'b0;
        if (scan_more) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(i_r);
          i_nxt    = i_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && rd_r == FREE_WORD) begin
          free_nxt = free_r + CNT_W'(1);
        end
        if (!scan_more && !pend_r) begin
          state_nxt = ST_CNT_OUT;
        end
      end
      ST_CNT_OUT: begin
        if (slot_free) begin
          emit                  = 1'b1;
          emit_data.result_type = RES_COUNT;
          emit_data.last        = 1'b1;
          emit_data.free_total  = free_r;
          state_nxt             = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          emit                  = 1'b1;
          emit_data.result_type = RES_CHAIN;
          emit_data.last        = 1'b1;
          emit_data.empty_chain = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop_ok) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    n_r    <= n_nxt;
    cap_r  <= cap_nxt;
    i_r    <= i_nxt;
    free_r <= free_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd_head.entry_index)] <= cmd_head.entry_value;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_walk_under_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP || state_r == ST_READ) |-> (n_r < cap_r))
    else $error("walk position reached its cap");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (free_r <= i_r))
    else $error("free count ahead of scanned entries");

  a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pend_r) |-> $past(rd_en))
    else $error("scan compare without a table read");

  a_step_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && !cur_ge_count) |=> (state_r == ST_READ))
    else $error("in-range walk step did not read the table");
`endif

endmodule

/* src/fat_cluster_chain_walker_unit.sv */
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker_unit
// allocation table store with chain walk and free entry count
// ----------------------------------------------------------------------------
// Items enter through a queue-style port (push/full) and results leave through
// one (empty/pop). A front end takes each item while its queue is not full,
// works out the walk cap and queues a command; a back end that owns the table
// memory carries commands out, so new items are taken while results wait to be
// popped. The table memory has one registered read port: in the back end a write
// is done at dispatch; a walk presents each cluster's address and then emits it
// once the registered read data is back, a cluster at or beyond the table count
// is emitted without a read, and an empty walk gives one empty-chain result; a
// free count reads the table one entry per cycle, then emits the total.
// Popping slower than results appear stalls the back end. The table needs no
// clearing pass: reading an entry that was never written gives an undefined
// word. The entry count register is written through cfg_valid/cfg_ready, always
// ready, and must only be changed while the unit has no transaction in flight.
// ----------------------------------------------------------------------------
module fat_cluster_chain_walker_unit #(
  parameter int TABLE_DEPTH = fccw_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_CHAIN   = fccw_pkg::DEF_MAX_CHAIN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input transactions
  input  logic                       in_push,
  output logic                       in_full,
  input  fccw_pkg::in_item_t         in_data,
  // result transactions
  output logic                       out_empty,
  input  logic                       out_pop,
  output fccw_pkg::out_item_t        out_data,
  // entry count register
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fccw_pkg::CNT_W-1:0] cfg_data
);
  import fccw_pkg::*;

  logic [CNT_W-1:0] table_entry_count_r;
  logic [CNT_W-1:0] eff_count;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_entry_count_r <= '0;
    end else if (cfg_valid) begin
      table_entry_count_r <= cfg_data;
    end
  end

  // count above the table depth saturates to the depth
  assign eff_count = ({{(32-CNT_W){1'b0}}, table_entry_count_r} > 32'(TABLE_DEPTH)) ?
                     CNT_W'(TABLE_DEPTH) : table_entry_count_r;

  fccw_front #(
    .MAX_CHAIN (MAX_CHAIN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .eff_count (eff_count),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head)
  );

  fccw_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head),
    .eff_count (eff_count),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
